// File: hw/rtl/efr_pkg.sv
`default_nettype none

package efr_pkg;

    localparam logic [7:0] HEAD_BYTE   = 8'h7E;
    localparam logic [7:0] TAIL_BYTE   = 8'hE7;
    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] ESC_HEAD    = 8'hEA;
    localparam logic [7:0] ESC_TAIL    = 8'hEB;
    localparam logic [7:0] ESC_ESC     = 8'h00;
    localparam logic [7:0] CMD_CAMERA  = 8'h00;
    localparam logic [7:0] CMD_SUCCESS = 8'h2C;
    localparam logic [7:0] CMD_FAILURE = 8'h29;
    localparam logic [7:0] CMD_READY   = 8'h3C;

    typedef enum logic [3:0] {
        EV_RELEASE_READY      = 4'd0,
        EV_CAPTURE_CONFIRMED  = 4'd1,
        EV_ACK_REQUEST        = 4'd2,
        EV_ROTATION_FAILED    = 4'd3,
        EV_SUCCESS_NO_PENDING = 4'd4,
        EV_BAD_ESCAPE         = 4'd5,
        EV_OVERFLOW           = 4'd6,
        EV_RESTART            = 4'd7,
        EV_TOO_SHORT          = 4'd8,
        EV_CHECKSUM_BAD       = 4'd9,
        EV_BAD_SIZE_CMD       = 4'd10,
        EV_SHORT_OTHER_CMD    = 4'd11
    } event_kind_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [15:0] frame_sequence;
        logic [7:0]  gripper_number;
        logic        replaced_pending;
    } efr_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/efr_in_stage.sv
`default_nettype none

module efr_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    assign s_tready      = !in_valid_reg || take;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign item_valid    = in_valid_reg;
    assign item_byte     = in_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/efr_frame_core.sv
`default_nettype none

module efr_frame_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fire,
    input  wire logic [7:0]   rx_byte,
    output efr_pkg::efr_result_t res
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    logic          inside_reg,  inside_next;
    logic          esc_reg,     esc_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [7:0]    sum_reg,     sum_next;
    logic [7:0]    last_reg,    last_next;
    logic          pend_reg,    pend_next;
    logic [15:0]   pseq_reg,    pseq_next;
    logic [7:0]    pgrip_reg,   pgrip_next;
    logic [7:0]    hdr_reg [4];
    logic          hdr_we;

    logic [7:0]    app_byte;
    logic          do_append;
    logic [7:0]    dec_byte;
    logic          dec_ok;
    logic [7:0]    cmd;
    logic          is_short;
    logic          is_camera;

    always_comb
    begin
        dec_ok   = 1'b1;
        dec_byte = efr_pkg::HEAD_BYTE;
        case (rx_byte)
            efr_pkg::ESC_HEAD: dec_byte = efr_pkg::HEAD_BYTE;
            efr_pkg::ESC_TAIL: dec_byte = efr_pkg::TAIL_BYTE;
            efr_pkg::ESC_ESC:  dec_byte = efr_pkg::ESC_BYTE;
            default:           dec_ok   = 1'b0;
        endcase
    end

    assign cmd       = hdr_reg[3];
    assign is_short  = (count_reg == CW'(5));
    assign is_camera = (count_reg == CW'(8)) && (cmd == efr_pkg::CMD_CAMERA);

    always_comb
    begin
        inside_next = inside_reg;
        esc_next    = esc_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        pseq_next   = pseq_reg;
        pgrip_next  = pgrip_reg;
        do_append   = 1'b0;
        app_byte    = rx_byte;
        res         = '0;

        if (!inside_reg)
        begin
            if (rx_byte == efr_pkg::HEAD_BYTE)
            begin
                inside_next = 1'b1;
                esc_next    = 1'b0;
                count_next  = '0;
                sum_next    = '0;
                last_next   = '0;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            if (dec_ok)
            begin
                do_append = 1'b1;
                app_byte  = dec_byte;
            end
            else
            begin
                inside_next = 1'b0;
                count_next  = '0;
                sum_next    = '0;
                last_next   = '0;
                res.valid   = 1'b1;
                res.kind    = efr_pkg::EV_BAD_ESCAPE;
            end
        end
        else if (rx_byte == efr_pkg::ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else if (rx_byte == efr_pkg::TAIL_BYTE)
        begin
            inside_next = 1'b0;
            count_next  = '0;
            sum_next    = '0;
            last_next   = '0;
            res.valid   = 1'b1;
            if (count_reg < CW'(5))
            begin
                res.kind = efr_pkg::EV_TOO_SHORT;
            end
            // checksum byte is the last one; the rest must sum to it
            else if (8'(sum_reg - last_reg) != last_reg)
            begin
                res.kind = efr_pkg::EV_CHECKSUM_BAD;
            end
            else if (!is_short && !is_camera)
            begin
                res.kind = efr_pkg::EV_BAD_SIZE_CMD;
            end
            else if (cmd == efr_pkg::CMD_READY)
            begin
                res.kind = efr_pkg::EV_RELEASE_READY;
            end
            else if (cmd == efr_pkg::CMD_SUCCESS)
            begin
                if (!pend_reg)
                begin
                    res.kind = efr_pkg::EV_SUCCESS_NO_PENDING;
                end
                else
                begin
                    pend_next          = 1'b0;
                    res.kind           = efr_pkg::EV_CAPTURE_CONFIRMED;
                    res.frame_sequence = pseq_reg;
                    res.gripper_number = pgrip_reg;
                end
            end
            else if (cmd == efr_pkg::CMD_FAILURE)
            begin
                pend_next = 1'b0;
                res.kind  = efr_pkg::EV_ROTATION_FAILED;
            end
            else if (!is_camera)
            begin
                res.kind = efr_pkg::EV_SHORT_OTHER_CMD;
            end
            else
            begin
                pend_next            = 1'b1;
                pseq_next            = {hdr_reg[0], hdr_reg[1]};
                pgrip_next           = hdr_reg[2];
                res.kind             = efr_pkg::EV_ACK_REQUEST;
                res.frame_sequence   = {hdr_reg[0], hdr_reg[1]};
                res.gripper_number   = hdr_reg[2];
                res.replaced_pending = pend_reg;
            end
        end
        else if (rx_byte == efr_pkg::HEAD_BYTE)
        begin
            count_next = '0;
            sum_next   = '0;
            last_next  = '0;
            res.valid  = 1'b1;
            res.kind   = efr_pkg::EV_RESTART;
        end
        else
        begin
            do_append = 1'b1;
        end

        if (do_append)
        begin
            if (count_reg == CW'(MAX_FRAME_BYTES))
            begin
                inside_next = 1'b0;
                count_next  = '0;
                sum_next    = '0;
                last_next   = '0;
                res.valid   = 1'b1;
                res.kind    = efr_pkg::EV_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                sum_next   = sum_reg + app_byte;
                last_next  = app_byte;
            end
        end
    end

    assign hdr_we = fire && do_append && (count_reg < CW'(4));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            sum_reg    <= '0;
            last_reg   <= '0;
            pend_reg   <= 1'b0;
            pseq_reg   <= '0;
            pgrip_reg  <= '0;
        end
        else if (fire)
        begin
            inside_reg <= inside_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            pseq_reg   <= pseq_next;
            pgrip_reg  <= pgrip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[count_reg[1:0]] <= app_byte;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/escaped_frame_receiver_unit.sv
// Path: an accepted byte is held in the input stage register, and its result is then registered
// in the output register that drives m_tvalid; a stalled result can hold the byte in between.
// Throughput: one byte per cycle, set by the frame state update; a result held by m_tready low
// stalls the input. Bytes that cause no result also advance at that rate.
// Reset: rst_n asynchronous active low; clears frame and pending state and both valid flags.
`default_nettype none

module escaped_frame_receiver_unit #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] frame_sequence, [23:16] gripper_number,
                                        // [24] replaced_pending, [31:25] zero
    output logic [3:0]       m_tuser    // [3:0] event_kind
);

    logic                 item_valid;
    logic [7:0]           item_byte;
    logic                 out_free;
    logic                 fire;
    efr_pkg::efr_result_t res;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    efr_pkg::efr_result_t out_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = item_valid && out_free;

    efr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    efr_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (item_byte),
        .res     (res)
    );

    assign out_valid_next = out_free ? (fire && res.valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.replaced_pending, out_reg.gripper_number,
                       out_reg.frame_sequence};

endmodule

`default_nettype wire

// File: hw/rtl/efr_checker.sv
`default_nettype none

module efr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= efr_pkg::EV_SHORT_OTHER_CMD)
        else $error("undefined event kind");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != efr_pkg::EV_ACK_REQUEST
            && m_tuser != efr_pkg::EV_CAPTURE_CONFIRMED |-> m_tdata == 32'd0)
        else $error("payload set on event without sequence");

    a_repl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == efr_pkg::EV_CAPTURE_CONFIRMED |-> !m_tdata[24])
        else $error("replaced flag on confirmed capture");

    // input only backs up behind a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked without a stalled result");

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (.*);

`default_nettype wire
